// File: sv/ihs_pkg.sv
`default_nettype none

package ihs_pkg;

    // Heap geometry and key width.
    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 48;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = IDX_W + 2;
    localparam int ID_W    = 4;
    localparam int IN_TIME_W  = 48;
    localparam int SUM_W   = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    localparam logic [TIME_BITS-1:0] KEY_MAX = {TIME_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [7:0] REG_DEADLINE_MODE = 8'd0;
    localparam logic [7:0] REG_BURNOUT_LIMIT = 8'd1;

    // Request kinds.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_DUP    = 2'd2,
        STAT_ABSENT = 2'd3
    } status_t;

    typedef logic [IDX_W-1:0]     slot_idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CHILD_W-1:0]   child_t;
    typedef logic [TIME_BITS-1:0] key_t;
    typedef logic [ID_W-1:0]      req_id_t;

    typedef struct packed {
        req_id_t id;
        key_t    key;
    } entry_t;

    // Broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic      wr_en;
        slot_idx_t wr_idx;
        entry_t    wr_entry;
        req_id_t   query_id;
        cnt_t      count;
        cnt_t      last_idx;
        slot_idx_t parent_idx;
        child_t    left_idx;
        child_t    right_idx;
    } cell_cmd_t;

    // Gathered along the row of cells; each cell ORs in what it owns.
    typedef struct packed {
        logic      match;
        slot_idx_t match_idx;
        entry_t    last;
        entry_t    parent;
        entry_t    left;
        entry_t    right;
        entry_t    head;
    } cell_bus_t;

endpackage

`default_nettype wire

// File: sv/indexed_min_heap_scheduler.sv
// Flow: a request is checked against the heap, then the entry moves up or down the heap level by level
// until it is placed, and then the result is registered.
// Throughput: one request at a time; the next one can be accepted in the cycle the result appears,
// and later while the result side stalls.
// Reset (aresetn, synchronous, active low) empties the heap at once and clears both
// configuration registers; no clearing pass is needed.
`default_nettype none

module indexed_min_heap_scheduler (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // Configuration writes: index 0 is deadline_mode, index 1 is burnout_limit.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,

    // Request channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata from bit 0: requester_id[3:0], last_done_time[51:4], now_time[99:52], zero pad.
    input  wire logic [103:0] s_tdata,
    // tuser: action (0 insert, 1 remove).
    input  wire logic         s_tuser,

    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata from bit 0: head_valid[0], head_id[4:1], head_key[52:5], entry_count[57:53], pad.
    output logic [63:0]       m_tdata,
    // tuser: status (0 ok, 1 full, 2 already queued, 3 not queued).
    output logic [1:0]        m_tuser
);
    import ihs_pkg::*;

    // The sequencer walks one heap level per cycle. It keeps the entry that is
    // moving in cur_reg and only writes it into a slot once its final place is
    // known; every entry it passes is copied one level over instead of swapped.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_UP,
        ST_DOWN,
        ST_DONE
    } state_t;

    state_t    state_reg,  state_next;
    slot_idx_t cursor_reg, cursor_next;
    cnt_t      count_reg,  count_next;
    entry_t    cur_reg,    cur_next;
    status_t   status_reg, status_next;
    logic      deadline_mode_reg, deadline_mode_next;
    logic [31:0] burnout_limit_reg, burnout_limit_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg,  m_tdata_next;
    logic [1:0]  m_tuser_reg,  m_tuser_next;

    cell_cmd_t cmd;
    cell_bus_t bus_chain [CAPACITY+1];
    cell_bus_t bus;

    // Request fields.
    req_id_t               in_id;
    logic [IN_TIME_W-1:0]  in_last_done;
    logic [IN_TIME_W-1:0]  in_now;
    logic [SUM_W-1:0]      deadline_sum;
    key_t                  new_key;
    logic                  in_accept;

    // Sift-down child selection.
    logic   left_ok;
    logic   right_ok;
    logic   take_right;
    entry_t child;
    child_t child_idx;

    assign in_id        = s_tdata[ID_W-1:0];
    assign in_last_done = s_tdata[ID_W+IN_TIME_W-1:ID_W];
    assign in_now       = s_tdata[ID_W+2*IN_TIME_W-1:ID_W+IN_TIME_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // In deadline mode the key is the last completion time plus the burnout
    // limit, clipped to the largest key that fits.
    always_comb begin
        deadline_sum = SUM_W'(key_t'(in_last_done)) + SUM_W'(burnout_limit_reg);
        if (deadline_mode_reg) begin
            new_key = (deadline_sum > SUM_W'(KEY_MAX)) ? KEY_MAX : key_t'(deadline_sum);
        end else begin
            new_key = key_t'(in_now);
        end
    end

    // The row of slot cells. Slot i sits in cell i; lookups ripple down the row.
    assign bus_chain[0] = '0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ihs_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(g)),
            .cmd        (cmd),
            .bus_in     (bus_chain[g]),
            .bus_out    (bus_chain[g+1])
        );
    end
    assign bus = bus_chain[CAPACITY];

    // Children of the cursor slot, and which one sift-down compares against.
    always_comb begin
        left_ok    = cmd.left_idx < CHILD_W'(count_reg);
        right_ok   = cmd.right_idx < CHILD_W'(count_reg);
        take_right = right_ok && (bus.right.key < bus.left.key);
        child      = take_right ? bus.right : bus.left;
        child_idx  = take_right ? cmd.right_idx : cmd.left_idx;
    end

    always_comb begin
        state_next         = state_reg;
        cursor_next        = cursor_reg;
        count_next         = count_reg;
        cur_next           = cur_reg;
        status_next        = status_reg;
        deadline_mode_next = deadline_mode_reg;
        burnout_limit_next = burnout_limit_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;

        // Lookups are always aimed at the cursor and its neighbors, and at the
        // current last slot for the move that fills a removed slot.
        cmd            = '0;
        cmd.query_id   = in_id;
        cmd.count      = count_reg;
        cmd.last_idx   = count_reg - CNT_W'(1);
        cmd.parent_idx = (cursor_reg - IDX_W'(1)) >> 1;
        cmd.left_idx   = CHILD_W'({cursor_reg, 1'b1});
        cmd.right_idx  = CHILD_W'({cursor_reg, 1'b0}) + CHILD_W'(2);

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEADLINE_MODE: deadline_mode_next = cfg_data[0];
                REG_BURNOUT_LIMIT: burnout_limit_next = cfg_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    status_next = STAT_OK;
                    if (s_tuser == ACT_INSERT) begin
                        if (bus.match) begin
                            status_next = STAT_DUP;
                            state_next  = ST_DONE;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            // The new entry starts in the first free slot.
                            cur_next    = '{id: in_id, key: new_key};
                            cursor_next = count_reg[IDX_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                            state_next  = ST_UP;
                        end
                    end else begin
                        if (!bus.match) begin
                            status_next = STAT_ABSENT;
                            state_next  = ST_DONE;
                        end else begin
                            // The last entry moves into the freed slot. When the
                            // freed slot is the last one, it is simply dropped.
                            count_next  = count_reg - CNT_W'(1);
                            cursor_next = bus.match_idx;
                            cur_next    = bus.last;
                            if (CNT_W'(bus.match_idx) >= count_reg - CNT_W'(1)) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_REMOVE;
                            end
                        end
                    end
                end
            end

            ST_REMOVE: begin
                // The moved entry goes up when it beats its parent, else down.
                if ((cursor_reg != '0) && (cur_reg.key < bus.parent.key)) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_idx   = cursor_reg;
                    cmd.wr_entry = bus.parent;
                    cursor_next  = cmd.parent_idx;
                    state_next   = ST_UP;
                end else begin
                    state_next = ST_DOWN;
                end
            end

            ST_UP: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = cursor_reg;
                if ((cursor_reg != '0) && (cur_reg.key < bus.parent.key)) begin
                    cmd.wr_entry = bus.parent;
                    cursor_next  = cmd.parent_idx;
                end else begin
                    cmd.wr_entry = cur_reg;
                    state_next   = ST_DONE;
                end
            end

            ST_DOWN: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = cursor_reg;
                if (left_ok && !(cur_reg.key <= child.key)) begin
                    cmd.wr_entry = child;
                    cursor_next  = child_idx[IDX_W-1:0];
                end else begin
                    cmd.wr_entry = cur_reg;
                    state_next   = ST_DONE;
                end
            end

            ST_DONE: begin
                // The heap is settled; report head and count once the output
                // register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = '0;
                    if (count_reg != '0) begin
                        m_tdata_next[0]   = 1'b1;
                        m_tdata_next[4:1] = bus.head.id;
                        m_tdata_next[52:5] = IN_TIME_W'(bus.head.key);
                    end
                    m_tdata_next[57:53] = 5'(count_reg);
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            deadline_mode_reg <= 1'b0;
            burnout_limit_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            deadline_mode_reg <= deadline_mode_next;
            burnout_limit_reg <= burnout_limit_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        cursor_reg  <= cursor_next;
        cur_reg     <= cur_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

`default_nettype wire

// File: sv/ihs_cell.sv
`default_nettype none

module ihs_cell (
    input  wire logic               aclk,
    input  wire ihs_pkg::slot_idx_t cell_index,
    input  wire ihs_pkg::cell_cmd_t cmd,
    input  wire ihs_pkg::cell_bus_t bus_in,
    output ihs_pkg::cell_bus_t      bus_out
);
    import ihs_pkg::*;

    entry_t entry_reg;
    logic   occupied;
    logic   hit;
    logic   is_last;
    logic   is_parent;
    logic   is_left;
    logic   is_right;
    logic   is_head;

    // One heap slot. It is loaded when the sequencer addresses it.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (cmd.wr_idx == cell_index)) begin
            entry_reg <= cmd.wr_entry;
        end
    end

    always_comb begin
        occupied  = CNT_W'(cell_index) < cmd.count;
        hit       = occupied && (entry_reg.id == cmd.query_id);
        is_last   = CNT_W'(cell_index) == cmd.last_idx;
        is_parent = cell_index == cmd.parent_idx;
        is_left   = CHILD_W'(cell_index) == cmd.left_idx;
        is_right  = CHILD_W'(cell_index) == cmd.right_idx;
        is_head   = cell_index == '0;

        bus_out.match     = bus_in.match | hit;
        bus_out.match_idx = bus_in.match_idx | (hit ? cell_index : '0);
        bus_out.last      = bus_in.last   | (is_last   ? entry_reg : '0);
        bus_out.parent    = bus_in.parent | (is_parent ? entry_reg : '0);
        bus_out.left      = bus_in.left   | (is_left   ? entry_reg : '0);
        bus_out.right     = bus_in.right  | (is_right  ? entry_reg : '0);
        bus_out.head      = bus_in.head   | (is_head   ? entry_reg : '0);
    end

endmodule

`default_nettype wire
